[rtl/aesir_pkg.sv]
// Package for the AES inverse round: round kinds, inverse S-box and GF(2^8) helpers.
package aesir_pkg;

    typedef enum logic [1:0] {
        KIND_INIT  = 2'd0,
        KIND_MID   = 2'd1,
        KIND_FINAL = 2'd2,
        KIND_SPARE = 2'd3
    } kind_t;

    localparam logic [7:0] INV_SBOX [256] = '{
        8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
        8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
        8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
        8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
        8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
        8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
        8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
        8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
        8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
        8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
        8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
        8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
        8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
        8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
        8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
        8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
    };

    // Multiply by x in GF(2^8) with the AES polynomial.
    function automatic logic [7:0] xt(input logic [7:0] a);
        xt = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [7:0] mul9(input logic [7:0] a);
        logic [7:0] a8;
        a8 = xt(xt(xt(a)));
        mul9 = a8 ^ a;
    endfunction

    function automatic logic [7:0] mul11(input logic [7:0] a);
        logic [7:0] a2;
        logic [7:0] a8;
        a2 = xt(a);
        a8 = xt(xt(a2));
        mul11 = a8 ^ a2 ^ a;
    endfunction

    function automatic logic [7:0] mul13(input logic [7:0] a);
        logic [7:0] a4;
        logic [7:0] a8;
        a4 = xt(xt(a));
        a8 = xt(a4);
        mul13 = a8 ^ a4 ^ a;
    endfunction

    function automatic logic [7:0] mul14(input logic [7:0] a);
        logic [7:0] a2;
        logic [7:0] a4;
        logic [7:0] a8;
        a2 = xt(a);
        a4 = xt(a2);
        a8 = xt(a4);
        mul14 = a8 ^ a4 ^ a2;
    endfunction

    // Inverse S-box on every byte, then row r rotates right by r columns.
    // Byte 4*c+r sits at bits [127-8*(4*c+r) -: 8].
    function automatic logic [127:0] inv_sub_shift(input logic [127:0] s);
        logic [127:0] t;
        int src;
        t = '0;
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                src = 4 * ((c + 4 - r) % 4) + r;
                t[127 - 8 * (4 * c + r) -: 8] = INV_SBOX[s[127 - 8 * src -: 8]];
            end
        end
        inv_sub_shift = t;
    endfunction

endpackage

[rtl/aesir_inv_mix.sv]
// Inverse column mix over the four columns of a 128-bit AES state.
module aesir_inv_mix (
    input  logic [127:0] din,
    output logic [127:0] dout
);

    always_comb
    begin
        logic [7:0] a0;
        logic [7:0] a1;
        logic [7:0] a2;
        logic [7:0] a3;
        dout = '0;
        for (int c = 0; c < 4; c++)
        begin
            a0 = din[127 - 32 * c -: 8];
            a1 = din[119 - 32 * c -: 8];
            a2 = din[111 - 32 * c -: 8];
            a3 = din[103 - 32 * c -: 8];
            dout[127 - 32 * c -: 8] = aesir_pkg::mul14(a0) ^ aesir_pkg::mul11(a1)
                                    ^ aesir_pkg::mul13(a2) ^ aesir_pkg::mul9(a3);
            dout[119 - 32 * c -: 8] = aesir_pkg::mul9(a0) ^ aesir_pkg::mul14(a1)
                                    ^ aesir_pkg::mul11(a2) ^ aesir_pkg::mul13(a3);
            dout[111 - 32 * c -: 8] = aesir_pkg::mul13(a0) ^ aesir_pkg::mul9(a1)
                                    ^ aesir_pkg::mul14(a2) ^ aesir_pkg::mul11(a3);
            dout[103 - 32 * c -: 8] = aesir_pkg::mul11(a0) ^ aesir_pkg::mul13(a1)
                                    ^ aesir_pkg::mul9(a2) ^ aesir_pkg::mul14(a3);
        end
    end

endmodule

[rtl/aes_inverse_round.sv]
// Top level of the pipelined AES inverse-cipher round.
//
// One round item is taken per clock while in_stall is low; the item then passes three
// register stages before its result is offered: inverse S-box lookup with the
// row shift, round-key addition, and the inverse column mix. The middle kind runs all
// three steps, the final kind skips the column mix, and the initial kind (and the unused
// code 3) only adds the round key. Each stage holds its item while the stage after it is
// full and stalled, so a stalled output never loses or repeats a transfer, and the
// input stall rises only when all three stages are full and the output is stalled.
module aes_inverse_round (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  kind,
    input  logic [63:0] state_hi,
    input  logic [63:0] state_lo,
    input  logic [63:0] round_key_hi,
    input  logic [63:0] round_key_lo,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [63:0] next_hi,
    output logic [63:0] next_lo
);

    logic         v1_reg;
    logic         v2_reg;
    logic         v3_reg;
    logic         ready1;
    logic         ready2;
    logic         ready3;
    logic [127:0] st1_reg;
    logic [127:0] st1_next;
    logic [127:0] key1_reg;
    logic         mix1_reg;
    logic [127:0] st2_reg;
    logic         mix2_reg;
    logic [127:0] out_reg;
    logic [127:0] mixed;
    logic         sub_en;
    logic         mix_en;

    assign ready3   = !v3_reg || !out_stall;
    assign ready2   = !v2_reg || ready3;
    assign ready1   = !v1_reg || ready2;
    assign in_stall = !ready1;

    assign sub_en = (aesir_pkg::kind_t'(kind) == aesir_pkg::KIND_MID)
                 || (aesir_pkg::kind_t'(kind) == aesir_pkg::KIND_FINAL);
    assign mix_en = (aesir_pkg::kind_t'(kind) == aesir_pkg::KIND_MID);

    assign st1_next = sub_en ? aesir_pkg::inv_sub_shift({state_hi, state_lo})
                             : {state_hi, state_lo};

    aesir_inv_mix u_mix (
        .din  (st2_reg),
        .dout (mixed)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (ready1)
            begin
                v1_reg <= in_valid;
            end
            if (ready2)
            begin
                v2_reg <= v1_reg;
            end
            if (ready3)
            begin
                v3_reg <= v2_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready1)
        begin
            st1_reg  <= st1_next;
            key1_reg <= {round_key_hi, round_key_lo};
            mix1_reg <= mix_en;
        end
        if (ready2)
        begin
            st2_reg  <= st1_reg ^ key1_reg;
            mix2_reg <= mix1_reg;
        end
        if (ready3)
        begin
            out_reg <= mix2_reg ? mixed : st2_reg;
        end
    end

    assign out_valid = v3_reg;
    assign next_hi   = out_reg[127:64];
    assign next_lo   = out_reg[63:0];

    // A free output stage must never hold back the input side.
    a_no_false_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !out_stall |-> !in_stall)
        else $error("input stalled while the output side was free");

    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> v1_reg)
        else $error("accepted transfer did not enter the first stage");

    a_stage2_holds: assert property (@(posedge clk) disable iff (!rst_n)
        v2_reg && v3_reg && out_stall |=> v2_reg && $stable(st2_reg) && $stable(mix2_reg))
        else $error("second stage changed while blocked");

    a_bypass_mix: assert property (@(posedge clk) disable iff (!rst_n)
        v2_reg && ready3 && !mix2_reg |=> out_reg == $past(st2_reg))
        else $error("column mix applied to a round that skips it");

endmodule

[test/aes_inverse_round_tb.sv]
// Self-checking testbench for the AES inverse round with a scoreboard and random flow control.
module aes_inverse_round_tb;

    localparam int CYCLE_LIMIT = 200000;
    localparam int RANDOM_ROUNDS = 500;
    localparam int QUIET_ROUNDS = 100;
    localparam int LONG_HOLD = 60;

    // Tracks expected next states in transfer order.
    class round_scoreboard;
        logic [127:0] pending[$];
        logic [7:0] inv_sub [256];
        int errors;

        function new();
            logic [7:0] b;
            logic [7:0] s;
            errors = 0;
            // Derive the inverse S-box from field inversion and the affine map.
            for (int x = 0; x < 256; x++)
            begin
                b = 8'h01;
                for (int i = 0; i < 254; i++)
                    b = gf_mul(b, x[7:0]);
                s = b ^ {b[6:0], b[7]} ^ {b[5:0], b[7:6]} ^ {b[4:0], b[7:5]}
                    ^ {b[3:0], b[7:4]} ^ 8'h63;
                inv_sub[s] = x[7:0];
            end
        endfunction

        function logic [7:0] gf_mul(logic [7:0] a, logic [7:0] m);
            logic [7:0] r;
            r = 8'h00;
            for (int i = 0; i < 8; i++)
            begin
                if (m[i])
                    r ^= a;
                a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
            end
            return r;
        endfunction

        function void note_input(aesir_pkg::kind_t k, logic [127:0] st, logic [127:0] key);
            logic [7:0] s [16];
            logic [7:0] t [16];
            logic [7:0] a0, a1, a2, a3;
            logic [127:0] v;
            for (int i = 0; i < 16; i++)
                s[i] = st[127 - 8 * i -: 8];
            if (k == aesir_pkg::KIND_MID || k == aesir_pkg::KIND_FINAL)
            begin
                // Row r of the result comes from r columns to its left.
                for (int c = 0; c < 4; c++)
                    for (int r = 0; r < 4; r++)
                        t[4 * c + r] = inv_sub[s[4 * ((c + 4 - r) % 4) + r]];
                s = t;
            end
            for (int i = 0; i < 16; i++)
                s[i] ^= key[127 - 8 * i -: 8];
            if (k == aesir_pkg::KIND_MID)
            begin
                for (int c = 0; c < 4; c++)
                begin
                    a0 = s[4 * c];
                    a1 = s[4 * c + 1];
                    a2 = s[4 * c + 2];
                    a3 = s[4 * c + 3];
                    s[4 * c] = gf_mul(a0, 8'd14) ^ gf_mul(a1, 8'd11) ^ gf_mul(a2, 8'd13)
                        ^ gf_mul(a3, 8'd9);
                    s[4 * c + 1] = gf_mul(a0, 8'd9) ^ gf_mul(a1, 8'd14) ^ gf_mul(a2, 8'd11)
                        ^ gf_mul(a3, 8'd13);
                    s[4 * c + 2] = gf_mul(a0, 8'd13) ^ gf_mul(a1, 8'd9) ^ gf_mul(a2, 8'd14)
                        ^ gf_mul(a3, 8'd11);
                    s[4 * c + 3] = gf_mul(a0, 8'd11) ^ gf_mul(a1, 8'd13) ^ gf_mul(a2, 8'd9)
                        ^ gf_mul(a3, 8'd14);
                end
            end
            for (int i = 0; i < 16; i++)
                v[127 - 8 * i -: 8] = s[i];
            pending.push_back(v);
        endfunction

        function void check_result(logic [63:0] hi, logic [63:0] lo);
            logic [127:0] want;
            if (pending.size() == 0)
            begin
                $error("unexpected result transfer: next_hi %h next_lo %h", hi, lo);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (hi !== want[127:64])
            begin
                $error("next_hi: expected %h, got %h", want[127:64], hi);
                errors++;
            end
            if (lo !== want[63:0])
            begin
                $error("next_lo: expected %h, got %h", want[63:0], lo);
                errors++;
            end
        endfunction
    endclass

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             in_valid = 1'b0;
    logic             in_stall;
    aesir_pkg::kind_t kind = aesir_pkg::KIND_INIT;
    logic [63:0]      state_hi = '0;
    logic [63:0]      state_lo = '0;
    logic [63:0]      round_key_hi = '0;
    logic [63:0]      round_key_lo = '0;
    logic             out_valid;
    logic             out_stall = 1'b0;
    logic [63:0]      next_hi;
    logic [63:0]      next_lo;

    bit quiet = 1'b0;
    bit long_hold_req = 1'b0;
    int cycles = 0;
    round_scoreboard rounds = new();

    aes_inverse_round u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .kind         (kind),
        .state_hi     (state_hi),
        .state_lo     (state_lo),
        .round_key_hi (round_key_hi),
        .round_key_lo (round_key_lo),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .next_hi      (next_hi),
        .next_lo      (next_lo)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            rounds.check_result(next_hi, next_lo);
    end

    // Output flow control: random stall bursts, plus one long hold-off on request.
    initial
    begin
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                out_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge clk);
                out_stall <= 1'b0;
            end
            else if (!quiet && $urandom_range(0, 4) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 6)) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    function automatic logic [127:0] rand128();
        return {$urandom, $urandom, $urandom, $urandom};
    endfunction

    // Offers one round and holds it until the input transfer completes.
    task automatic send_round(input aesir_pkg::kind_t k, input logic [127:0] st,
                              input logic [127:0] key);
        in_valid <= 1'b1;
        kind <= k;
        state_hi <= st[127:64];
        state_lo <= st[63:0];
        round_key_hi <= key[127:64];
        round_key_lo <= key[63:0];
        do
            @(posedge clk);
        while (in_stall);
        rounds.note_input(k, st, key);
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    endtask

    initial
    begin
        aesir_pkg::kind_t k;
        logic [127:0] key;
        int pick;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: every kind, including the unused code, with all-zero and all-one fields.
        for (int i = 0; i < 4; i++)
        begin
            k = aesir_pkg::kind_t'(i);
            send_round(k, '0, '0);
            send_round(k, '1, '1);
            send_round(k, '1, '0);
            send_round(k, '0, '1);
            send_round(k, rand128(), rand128());
        end

        long_hold_req = 1'b1;
        for (int n = 0; n < RANDOM_ROUNDS; n++)
        begin
            if (n == RANDOM_ROUNDS - QUIET_ROUNDS)
                quiet = 1'b1;
            pick = $urandom_range(0, 9);
            if (pick < 5)
                k = aesir_pkg::KIND_MID;
            else if (pick < 8)
                k = aesir_pkg::KIND_FINAL;
            else if (pick == 8)
                k = aesir_pkg::KIND_INIT;
            else
                k = aesir_pkg::KIND_SPARE;
            // A zero key now and then exposes the bare inverse transform.
            key = ($urandom_range(0, 7) == 0) ? '0 : rand128();
            send_round(k, rand128(), key);
        end
        in_valid <= 1'b0;

        while (rounds.pending.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (rounds.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule

[files.f]
rtl/aesir_pkg.sv
rtl/aesir_inv_mix.sv
rtl/aes_inverse_round.sv
test/aes_inverse_round_tb.sv
